// ===== hdl/pareto_archive_update_top_macros.svh =====
// Assertion helpers shared by the checker of the Pareto archive block.
// Both sample on the rising edge of clk and are quiet while rst is high.
`ifndef PARETO_ARCHIVE_UPDATE_TOP_MACROS_SVH
`define PARETO_ARCHIVE_UPDATE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pau_pkg.sv =====
package pau_pkg;

  localparam int MODE_W      = 2;
  localparam int COST_PORT_W = 32;
  localparam int SIG_W       = 64;
  localparam int IDX_W       = 5;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 6;
  localparam int OBJ_CFG_W   = 3;
  localparam int MAX_OBJ     = 4;

  localparam logic [OBJ_CFG_W-1:0] OBJ_RESET = 3'd4;

  localparam logic [MODE_W-1:0] MODE_OFFER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DOMINATED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_OFFER = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SETTLE,
    S_DONE
  } pau_state_t;

  // Outcome of comparing the candidate with one stored entry.
  typedef struct packed {
    logic cand_dom_entry;
    logic entry_dom_cand;
    logic sig_match;
  } pau_cmp_t;

endpackage

// ===== hdl/pau_offer_if.sv =====
interface pau_offer_if;
  import pau_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic [COST_PORT_W-1:0] cost_a;
  logic [COST_PORT_W-1:0] cost_b;
  logic [COST_PORT_W-1:0] cost_c;
  logic [COST_PORT_W-1:0] cost_d;
  logic [SIG_W-1:0]       signature;
  logic [IDX_W-1:0]       read_index;

  modport source (
    output valid, mode, cost_a, cost_b, cost_c, cost_d, signature, read_index,
    input  ready
  );

  modport sink (
    input  valid, mode, cost_a, cost_b, cost_c, cost_d, signature, read_index,
    output ready
  );
endinterface

// ===== hdl/pau_result_if.sv =====
interface pau_result_if;
  import pau_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    offer_status;
  logic [COUNT_OUT_W-1:0] removed_count;
  logic [COUNT_OUT_W-1:0] archive_count;
  logic                   read_valid;
  logic [COST_PORT_W-1:0] read_cost_a;
  logic [COST_PORT_W-1:0] read_cost_b;
  logic [COST_PORT_W-1:0] read_cost_c;
  logic [COST_PORT_W-1:0] read_cost_d;
  logic [SIG_W-1:0]       read_signature;

  modport source (
    output valid, offer_status, removed_count, archive_count, read_valid,
           read_cost_a, read_cost_b, read_cost_c, read_cost_d, read_signature,
    input  ready
  );

  modport sink (
    input  valid, offer_status, removed_count, archive_count, read_valid,
           read_cost_a, read_cost_b, read_cost_c, read_cost_d, read_signature,
    output ready
  );
endinterface

// ===== hdl/pau_cmp.sv =====
module pau_cmp #(
  parameter int NO = 4,
  parameter int CW = 32
) (
  input  logic [NO*CW-1:0]                cand_costs,
  input  logic [NO*CW-1:0]                entry_costs,
  input  logic [pau_pkg::SIG_W-1:0]       cand_sig,
  input  logic [pau_pkg::SIG_W-1:0]       entry_sig,
  input  logic [pau_pkg::OBJ_CFG_W-1:0]   n_active,
  output pau_pkg::pau_cmp_t               cmp
);
  import pau_pkg::*;

  logic cand_worse;
  logic cand_better;

  // One pair of magnitude compares per objective, shared by both
  // directions of the dominance test.
  always_comb begin
    cand_worse  = 1'b0;
    cand_better = 1'b0;
    for (int i = 0; i < NO; i++) begin
      if (OBJ_CFG_W'(i) < n_active) begin
        if (cand_costs[i*CW +: CW] > entry_costs[i*CW +: CW]) cand_worse  = 1'b1;
        if (cand_costs[i*CW +: CW] < entry_costs[i*CW +: CW]) cand_better = 1'b1;
      end
    end
  end

  assign cmp.cand_dom_entry = cand_better && !cand_worse;
  assign cmp.entry_dom_cand = cand_worse && !cand_better;
  assign cmp.sig_match      = (cand_sig == entry_sig);

endmodule

// ===== hdl/pau_store.sv =====
module pau_store #(
  parameter  int DEPTH = 32,
  parameter  int ROWW  = 192,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [ROWW-1:0] rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [ROWW-1:0] wr_data
);

  logic [ROWW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/pareto_archive_update_top.sv =====
// Pareto archive of up to ARCHIVE_DEPTH solutions, each a row of costs and a
// 64-bit signature held in one single-port-write, registered-read memory.
// An offer item walks the held entries one per cycle through a single
// dominance comparator, writing survivors back in order, and the block takes
// no new item until that item has passed the scan, settle and done states and
// is back in idle; read, clear and unused modes go from idle straight to done.
// The memory read port and the one comparator set the scan pace. The result
// sits in an output register, so the next item can start while a result still
// waits; that item then holds in its done state until the waiting result is
// taken. Entries are never cleared in memory: only the held count is reset,
// and no clearing pass runs.
module pareto_archive_update_top #(
  parameter int ARCHIVE_DEPTH  = 32,
  parameter int NUM_OBJECTIVES = 4,
  parameter int COST_WIDTH     = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pau_pkg::OBJ_CFG_W-1:0]   cfg_wdata,
  pau_offer_if.sink                       offer,
  pau_result_if.source                    result
);
  import pau_pkg::*;

  localparam int CW   = (COST_WIDTH < COST_PORT_W) ? COST_WIDTH : COST_PORT_W;
  localparam int NO   = NUM_OBJECTIVES;
  localparam int ROWW = SIG_W + NO * CW;
  localparam int CNTW = $clog2(ARCHIVE_DEPTH + 1);
  localparam int AW   = $clog2(ARCHIVE_DEPTH);
  localparam int CMPW = (CNTW > IDX_W) ? CNTW : IDX_W;

  pau_state_t state, state_next;

  logic [OBJ_CFG_W-1:0] cfg_obj;
  logic [OBJ_CFG_W-1:0] n_active;

  logic [CNTW-1:0] count;
  logic [CNTW-1:0] k;
  logic [CNTW-1:0] w;
  logic [CNTW-1:0] removed;
  logic            rd_v;
  logic            dom;
  logic            dup;
  logic            read_hit;
  logic [STATUS_W-1:0] status;

  logic [NO*CW-1:0] cand_costs;
  logic [NO*CW-1:0] cand_in;
  logic [SIG_W-1:0] cand_sig;
  logic [COST_PORT_W-1:0] in_cost [MAX_OBJ];
  logic [COST_PORT_W-1:0] out_cost [MAX_OBJ];

  logic            accept;
  logic            idx_hit;
  logic            issue;
  logic            append_ok;
  logic            out_load;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [ROWW-1:0] rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [ROWW-1:0] wr_data;
  pau_cmp_t        cmp;

  assign n_active = (cfg_obj == '0) ? OBJ_CFG_W'(1) :
                    (cfg_obj > OBJ_CFG_W'(NO)) ? OBJ_CFG_W'(NO) : cfg_obj;

  assign in_cost[0] = offer.cost_a;
  assign in_cost[1] = offer.cost_b;
  assign in_cost[2] = offer.cost_c;
  assign in_cost[3] = offer.cost_d;

  always_comb begin
    for (int i = 0; i < NO; i++) begin
      cand_in[i*CW +: CW] = CW'(in_cost[i]);
    end
  end

  assign accept    = offer.valid && offer.ready;
  assign idx_hit   = (CMPW'(offer.read_index) < CMPW'(count));
  assign issue     = (state == S_SCAN) && (k < count);
  assign append_ok = !dom && !dup && (w < CNTW'(ARCHIVE_DEPTH));

  pau_store #(
    .DEPTH (ARCHIVE_DEPTH),
    .ROWW  (ROWW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  pau_cmp #(
    .NO (NO),
    .CW (CW)
  ) u_cmp (
    .cand_costs  (cand_costs),
    .entry_costs (rd_data[NO*CW-1:0]),
    .cand_sig    (cand_sig),
    .entry_sig   (rd_data[ROWW-1 -: SIG_W]),
    .n_active    (n_active),
    .cmp         (cmp)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (offer.mode == MODE_OFFER) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        // The last read must have been compared before the scan ends.
        if (!issue && !rd_v) state_next = S_SETTLE;
      end
      S_SETTLE: state_next = S_DONE;
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    offer.ready = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = k[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = w[AW-1:0];
    wr_data     = rd_data;
    out_load    = 1'b0;
    case (state)
      S_IDLE: begin
        offer.ready = 1'b1;
        rd_addr     = AW'(offer.read_index);
        rd_en       = accept && (offer.mode == MODE_READ) && idx_hit;
      end
      S_SCAN: begin
        rd_en = issue;
        // Survivors move down to the write pointer, which never passes the
        // address being read.
        wr_en = rd_v && !cmp.cand_dom_entry;
      end
      S_SETTLE: begin
        wr_en   = append_ok;
        wr_data = {cand_sig, cand_costs};
      end
      S_DONE: begin
        out_load = !result.valid || result.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cfg_obj <= OBJ_RESET;
      count   <= '0;
      rd_v    <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue;
      if (cfg_we) cfg_obj <= cfg_wdata;
      if (accept && (offer.mode == MODE_CLEAR)) begin
        count <= '0;
      end else if (state == S_SETTLE) begin
        count <= append_ok ? (w + CNTW'(1)) : w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cand_costs <= cand_in;
      cand_sig   <= offer.signature;
      k          <= '0;
      w          <= '0;
      removed    <= '0;
      dom        <= 1'b0;
      dup        <= 1'b0;
      read_hit   <= (offer.mode == MODE_READ) && idx_hit;
      status     <= STAT_NOT_OFFER;
    end else if (state == S_SCAN) begin
      if (issue) k <= k + CNTW'(1);
      if (rd_v) begin
        if (cmp.entry_dom_cand) dom <= 1'b1;
        if (cmp.sig_match) dup <= 1'b1;
        if (cmp.cand_dom_entry) removed <= removed + CNTW'(1);
        else w <= w + CNTW'(1);
      end
    end else if (state == S_SETTLE) begin
      if (dom) status <= STAT_DOMINATED;
      else if (dup) status <= STAT_DUPLICATE;
      else if (!append_ok) status <= STAT_FULL;
      else status <= STAT_ADDED;
    end
  end

  for (genvar i = 0; i < MAX_OBJ; i++) begin : g_out_cost
    if (i < NO) begin : g_held
      assign out_cost[i] = read_hit ? COST_PORT_W'(rd_data[i*CW +: CW]) : '0;
    end else begin : g_absent
      assign out_cost[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.offer_status   <= status;
      result.removed_count  <= COUNT_OUT_W'(removed);
      result.archive_count  <= COUNT_OUT_W'(count);
      result.read_valid     <= read_hit;
      result.read_cost_a    <= out_cost[0];
      result.read_cost_b    <= out_cost[1];
      result.read_cost_c    <= out_cost[2];
      result.read_cost_d    <= out_cost[3];
      result.read_signature <= read_hit ? rd_data[ROWW-1 -: SIG_W] : '0;
    end
  end

endmodule

// ===== hdl/pau_checker.sv =====
`include "pareto_archive_update_top_macros.svh"

module pau_checker (
  input logic          clk,
  input logic          rst,
  pau_offer_if.sink    offer,
  pau_result_if.source result
);
  import pau_pkg::*;

  // A waiting result holds still until it is taken.
  `PAU_ASSERT_NEXT(a_result_hold, result.valid && !result.ready, result.valid && $stable(result.archive_count) && $stable(result.offer_status), "result changed while stalled")

  // Every item keeps the block busy in the cycle after acceptance.
  `PAU_ASSERT_NEXT(a_busy_after_accept, offer.valid && offer.ready, !offer.ready, "block ready right after accepting an item")

  // A successful read is never reported together with offer activity.
  `PAU_ASSERT_NOW(a_read_not_offer, result.valid && result.read_valid, result.offer_status == STAT_NOT_OFFER && result.removed_count == '0, "read result carries offer status")

  // Read fields are zero outside a successful read.
  `PAU_ASSERT_NOW(a_read_fields_zero, result.valid && !result.read_valid, result.read_signature == '0 && result.read_cost_a == '0, "read fields set without a valid read")

endmodule

bind pareto_archive_update_top pau_checker u_pau_checker (
  .clk    (clk),
  .rst    (rst),
  .offer  (offer),
  .result (result)
);
